[rtl/core/tmps_pkg.sv]
package tmps_pkg;

   // Widths of the request and response fields.
   localparam int FUNC_W  = 2;
   localparam int INDEX_W = 4;
   localparam int ELEM_W  = 32;
   localparam int VALUE_W = 64;
   localparam int SIZE_W  = 5;

   // Arithmetic widths: one signed 33 x 33 multiplier and a wide exact accumulator.
   localparam int MUL_W  = 33;
   localparam int PROD_W = 66;
   localparam int ACC_W  = 128;

   // Queue depths between the front end, the engine and the response side.
   localparam int CMD_DEPTH = 2;
   localparam int OUT_DEPTH = 2;

   localparam logic [SIZE_W-1:0] SIZE_RESET = 5'd16;

   // Request function codes.
   localparam logic [FUNC_W-1:0] FUNC_LOAD_A  = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_LOAD_B  = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_COMPUTE = 2'd2;
   localparam logic [FUNC_W-1:0] FUNC_READ    = 2'd3;

   typedef enum logic [2:0] {
      CMD_LOAD_A    = 3'd0,
      CMD_LOAD_B    = 3'd1,
      CMD_COMPUTE   = 3'd2,
      CMD_READ      = 3'd3,
      CMD_READ_ZERO = 3'd4,
      CMD_SKIP      = 3'd5
   } cmd_kind_type;

   typedef enum logic [4:0] {
      ST_IDLE      = 5'd0,
      ST_READ_RESP = 5'd1,
      ST_P1_RD     = 5'd2,
      ST_P1_MUL    = 5'd3,
      ST_P1_ACC    = 5'd4,
      ST_P1_WR     = 5'd5,
      ST_P2_CHECK  = 5'd6,
      ST_P2_RD     = 5'd7,
      ST_P2_MUL_LO = 5'd8,
      ST_P2_ACC_LO = 5'd9,
      ST_P2_MUL_HI = 5'd10,
      ST_P2_ACC_HI = 5'd11,
      ST_P2_SHIFT  = 5'd12,
      ST_P3_RD     = 5'd13,
      ST_P3_MUL    = 5'd14,
      ST_P3_ACC    = 5'd15,
      ST_P2_WR     = 5'd16
   } back_state_type;

endpackage

[rtl/core/tmps_ram.sv]
module tmps_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  logic                             clock,
   input  logic                             wr_en,
   input  logic [$clog2(DEPTH)-1:0]         wr_addr,
   input  logic [WIDTH-1:0]                 wr_data,
   input  logic                             rd_en,
   input  logic [$clog2(DEPTH)-1:0]         rd_addr,
   output logic [WIDTH-1:0]                 rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/core/tmps_front.sv]
module tmps_front #(
   parameter int MAX_ORDER = 16
) (
   input  logic                                      clock,
   input  logic                                      reset,
   input  logic                                      push,
   output logic                                      full,
   input  logic [tmps_pkg::FUNC_W-1:0]               func,
   input  logic [tmps_pkg::INDEX_W-1:0]              row_index,
   input  logic [tmps_pkg::INDEX_W-1:0]              col_index,
   input  logic signed [tmps_pkg::ELEM_W-1:0]        elem_value,
   output logic                                      cmd_valid,
   input  logic                                      cmd_pop,
   output tmps_pkg::cmd_kind_type                    cmd_kind,
   output logic [2*((MAX_ORDER > 1) ? $clog2(MAX_ORDER) : 1)-1:0] cmd_addr,
   output logic [tmps_pkg::ELEM_W-1:0]               cmd_value
);

   localparam int IDX_W   = (MAX_ORDER > 1) ? $clog2(MAX_ORDER) : 1;
   localparam int IDX_EXT = (IDX_W > tmps_pkg::INDEX_W) ? IDX_W : tmps_pkg::INDEX_W;
   localparam int ADDR_W  = 2 * IDX_W;
   localparam int PTR_W   = $clog2(tmps_pkg::CMD_DEPTH);
   localparam int QCNT_W  = $clog2(tmps_pkg::CMD_DEPTH + 1);

   logic [IDX_EXT-1:0]         row_ext;
   logic [IDX_EXT-1:0]         col_ext;
   logic                       in_range;
   tmps_pkg::cmd_kind_type     kind_in;
   logic                       push_ok;

   tmps_pkg::cmd_kind_type     kind_ff  [tmps_pkg::CMD_DEPTH];
   logic [ADDR_W-1:0]          addr_ff  [tmps_pkg::CMD_DEPTH];
   logic [tmps_pkg::ELEM_W-1:0] value_ff [tmps_pkg::CMD_DEPTH];
   logic [PTR_W-1:0]           wr_ptr_ff;
   logic [PTR_W-1:0]           rd_ptr_ff;
   logic [QCNT_W-1:0]          count_ff;

   // An index outside the matrix turns a load into a no-op and a read into a zero answer.
   always_comb begin
      row_ext  = IDX_EXT'(row_index);
      col_ext  = IDX_EXT'(col_index);
      in_range = ({4'd0, row_index} < 8'(MAX_ORDER)) && ({4'd0, col_index} < 8'(MAX_ORDER));
      case (func)
         tmps_pkg::FUNC_LOAD_A:  kind_in = in_range ? tmps_pkg::CMD_LOAD_A : tmps_pkg::CMD_SKIP;
         tmps_pkg::FUNC_LOAD_B:  kind_in = in_range ? tmps_pkg::CMD_LOAD_B : tmps_pkg::CMD_SKIP;
         tmps_pkg::FUNC_COMPUTE: kind_in = tmps_pkg::CMD_COMPUTE;
         tmps_pkg::FUNC_READ:    kind_in = in_range ? tmps_pkg::CMD_READ :
                                                      tmps_pkg::CMD_READ_ZERO;
         default:                kind_in = tmps_pkg::CMD_SKIP;
      endcase
   end

   assign full      = (count_ff == QCNT_W'(tmps_pkg::CMD_DEPTH));
   assign push_ok   = push && !full;
   assign cmd_valid = (count_ff != '0);
   assign cmd_kind  = kind_ff[rd_ptr_ff];
   assign cmd_addr  = addr_ff[rd_ptr_ff];
   assign cmd_value = value_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push_ok) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (cmd_pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         count_ff <= count_ff + QCNT_W'(push_ok) - QCNT_W'(cmd_pop);
      end
   end

   always_ff @(posedge clock) begin
      if (push_ok) begin
         kind_ff[wr_ptr_ff]  <= kind_in;
         addr_ff[wr_ptr_ff]  <= {row_ext[IDX_W-1:0], col_ext[IDX_W-1:0]};
         value_ff[wr_ptr_ff] <= elem_value;
      end
   end

endmodule

[rtl/core/tmps_back.sv]
module tmps_back #(
   parameter int MAX_ORDER = 16
) (
   input  logic                                      clock,
   input  logic                                      reset,
   input  logic [$clog2(MAX_ORDER + 1)-1:0]          n_eff,
   input  logic                                      cmd_valid,
   output logic                                      cmd_pop,
   input  tmps_pkg::cmd_kind_type                    cmd_kind,
   input  logic [2*((MAX_ORDER > 1) ? $clog2(MAX_ORDER) : 1)-1:0] cmd_addr,
   input  logic [tmps_pkg::ELEM_W-1:0]               cmd_value,
   input  logic                                      rsp_room,
   output logic                                      rsp_push,
   output logic [tmps_pkg::VALUE_W-1:0]              rsp_value,
   output logic                                      rsp_sat
);

   localparam int IDX_W  = (MAX_ORDER > 1) ? $clog2(MAX_ORDER) : 1;
   localparam int ADDR_W = 2 * IDX_W;
   localparam int DEPTH  = 1 << ADDR_W;
   localparam int CNT_W  = $clog2(MAX_ORDER + 1);
   localparam int EW     = tmps_pkg::ELEM_W;
   localparam int VW     = tmps_pkg::VALUE_W;
   localparam int AW     = tmps_pkg::ACC_W;
   localparam int PW     = tmps_pkg::PROD_W;
   localparam int MW     = tmps_pkg::MUL_W;

   function automatic logic [ADDR_W-1:0] cell_addr(input logic [CNT_W-1:0] r,
                                                   input logic [CNT_W-1:0] c);
      return {r[IDX_W-1:0], c[IDX_W-1:0]};
   endfunction

   tmps_pkg::back_state_type state_ff, state_in;
   logic [CNT_W-1:0]    i_ff, i_in, j_ff, j_in, k_ff, k_in;
   logic signed [AW-1:0] acc_ff, acc_in;
   logic signed [PW-1:0] prod_ff;
   logic                mark_ff, mark_in;

   logic                a_wr_en, a_rd_en, b_wr_en, b0_rd_en, b1_rd_en;
   logic                d_wr_en, d_rd_en, c_wr_en, c_rd_en;
   logic [ADDR_W-1:0]   a_rd_addr, b0_rd_addr, b1_rd_addr, d_wr_addr, d_rd_addr;
   logic [ADDR_W-1:0]   c_wr_addr, c_rd_addr;
   logic [VW:0]         d_wr_data, c_wr_data, d_rd_data, c_rd_data;
   logic [EW-1:0]       a_rd_data, b0_rd_data, b1_rd_data;

   logic signed [MW-1:0] op_a, op_b;
   logic signed [AW-1:0] prod_ext, acc_lo_sum, acc_hi_sum;
   logic                acc_fits;
   logic [VW-1:0]       acc_sat;
   logic [CNT_W-1:0]    n_last, order_last;

   tmps_ram #(.WIDTH(EW), .DEPTH(DEPTH)) u_ram_a (
      .clock(clock), .wr_en(a_wr_en), .wr_addr(cmd_addr), .wr_data(cmd_value),
      .rd_en(a_rd_en), .rd_addr(a_rd_addr), .rd_data(a_rd_data));

   // B is kept twice so that the two B operands of a term are read in the same cycle.
   tmps_ram #(.WIDTH(EW), .DEPTH(DEPTH)) u_ram_b0 (
      .clock(clock), .wr_en(b_wr_en), .wr_addr(cmd_addr), .wr_data(cmd_value),
      .rd_en(b0_rd_en), .rd_addr(b0_rd_addr), .rd_data(b0_rd_data));

   tmps_ram #(.WIDTH(EW), .DEPTH(DEPTH)) u_ram_b1 (
      .clock(clock), .wr_en(b_wr_en), .wr_addr(cmd_addr), .wr_data(cmd_value),
      .rd_en(b1_rd_en), .rd_addr(b1_rd_addr), .rd_data(b1_rd_data));

   // Intermediate product with its clamp mark in the top bit.
   tmps_ram #(.WIDTH(VW + 1), .DEPTH(DEPTH)) u_ram_d (
      .clock(clock), .wr_en(d_wr_en), .wr_addr(d_wr_addr), .wr_data(d_wr_data),
      .rd_en(d_rd_en), .rd_addr(d_rd_addr), .rd_data(d_rd_data));

   // Result with its saturation mark in the top bit.
   tmps_ram #(.WIDTH(VW + 1), .DEPTH(DEPTH)) u_ram_c (
      .clock(clock), .wr_en(c_wr_en), .wr_addr(c_wr_addr), .wr_data(c_wr_data),
      .rd_en(c_rd_en), .rd_addr(c_rd_addr), .rd_data(c_rd_data));

   // Shared multiplier. A 64-bit intermediate entry is taken in two halves.
   always_comb begin
      case (state_ff)
         tmps_pkg::ST_P1_MUL: begin
            op_a = MW'($signed(a_rd_data));
            op_b = MW'($signed(b0_rd_data));
         end
         tmps_pkg::ST_P2_MUL_LO: begin
            op_a = $signed({1'b0, d_rd_data[EW-1:0]});
            op_b = MW'($signed(a_rd_data));
         end
         tmps_pkg::ST_P2_MUL_HI: begin
            op_a = MW'($signed(d_rd_data[VW-1:EW]));
            op_b = MW'($signed(a_rd_data));
         end
         default: begin
            op_a = MW'($signed(b0_rd_data));
            op_b = MW'($signed(b1_rd_data));
         end
      endcase
   end

   always_comb begin
      prod_ext   = $signed({{(AW - PW){prod_ff[PW-1]}}, prod_ff});
      acc_lo_sum = acc_ff + prod_ext;
      acc_hi_sum = acc_ff + (prod_ext <<< EW);
      acc_fits   = (&acc_ff[AW-1:VW-1]) || !(|acc_ff[AW-1:VW-1]);
      acc_sat    = acc_fits ? acc_ff[VW-1:0] :
                   (acc_ff[AW-1] ? {1'b1, {(VW - 1){1'b0}}} : {1'b0, {(VW - 1){1'b1}}});
      n_last     = n_eff - CNT_W'(1);
      order_last = CNT_W'(MAX_ORDER - 1);
   end

   always_comb begin
      state_in   = state_ff;
      i_in       = i_ff;
      j_in       = j_ff;
      k_in       = k_ff;
      acc_in     = acc_ff;
      mark_in    = mark_ff;
      cmd_pop    = 1'b0;
      rsp_push   = 1'b0;
      rsp_value  = '0;
      rsp_sat    = 1'b0;
      a_wr_en    = 1'b0;
      b_wr_en    = 1'b0;
      a_rd_en    = 1'b0;
      b0_rd_en   = 1'b0;
      b1_rd_en   = 1'b0;
      d_wr_en    = 1'b0;
      d_rd_en    = 1'b0;
      c_wr_en    = 1'b0;
      c_rd_en    = 1'b0;
      a_rd_addr  = cell_addr(i_ff, k_ff);
      b0_rd_addr = cell_addr(k_ff, j_ff);
      b1_rd_addr = cell_addr(j_ff, k_ff);
      d_rd_addr  = cell_addr(i_ff, k_ff);
      d_wr_addr  = cell_addr(i_ff, j_ff);
      d_wr_data  = {!acc_fits, acc_sat};
      c_wr_addr  = cell_addr(i_ff, j_ff);
      c_wr_data  = {mark_ff || !acc_fits, acc_sat};
      c_rd_addr  = cmd_addr;

      case (state_ff)
         tmps_pkg::ST_IDLE: begin
            if (cmd_valid) begin
               case (cmd_kind)
                  tmps_pkg::CMD_LOAD_A: begin
                     cmd_pop = 1'b1;
                     a_wr_en = 1'b1;
                  end
                  tmps_pkg::CMD_LOAD_B: begin
                     cmd_pop = 1'b1;
                     b_wr_en = 1'b1;
                  end
                  tmps_pkg::CMD_COMPUTE: begin
                     cmd_pop  = 1'b1;
                     i_in     = '0;
                     j_in     = '0;
                     k_in     = '0;
                     acc_in   = '0;
                     state_in = tmps_pkg::ST_P1_RD;
                  end
                  tmps_pkg::CMD_READ: begin
                     if (rsp_room) begin
                        cmd_pop  = 1'b1;
                        c_rd_en  = 1'b1;
                        state_in = tmps_pkg::ST_READ_RESP;
                     end
                  end
                  tmps_pkg::CMD_READ_ZERO: begin
                     if (rsp_room) begin
                        cmd_pop  = 1'b1;
                        rsp_push = 1'b1;
                     end
                  end
                  default: begin
                     cmd_pop = 1'b1;
                  end
               endcase
            end
         end
         tmps_pkg::ST_READ_RESP: begin
            rsp_push  = 1'b1;
            rsp_value = c_rd_data[VW-1:0];
            rsp_sat   = c_rd_data[VW];
            state_in  = tmps_pkg::ST_IDLE;
         end
         // D[i][j] = sum over k >= i of A[i][k] * B[k][j].
         tmps_pkg::ST_P1_RD: begin
            a_rd_en  = 1'b1;
            b0_rd_en = 1'b1;
            state_in = tmps_pkg::ST_P1_MUL;
         end
         tmps_pkg::ST_P1_MUL: begin
            state_in = tmps_pkg::ST_P1_ACC;
         end
         tmps_pkg::ST_P1_ACC: begin
            acc_in = acc_lo_sum;
            if (k_ff == n_last) begin
               state_in = tmps_pkg::ST_P1_WR;
            end else begin
               k_in     = k_ff + 1'b1;
               state_in = tmps_pkg::ST_P1_RD;
            end
         end
         tmps_pkg::ST_P1_WR: begin
            d_wr_en  = 1'b1;
            acc_in   = '0;
            state_in = tmps_pkg::ST_P1_RD;
            if (j_ff == n_last) begin
               j_in = '0;
               if (i_ff == n_last) begin
                  i_in     = '0;
                  state_in = tmps_pkg::ST_P2_CHECK;
               end else begin
                  i_in = i_ff + 1'b1;
                  k_in = i_ff + 1'b1;
               end
            end else begin
               j_in = j_ff + 1'b1;
               k_in = i_ff;
            end
         end
         // C entries outside the order are cleared; inside ones start at k = j.
         tmps_pkg::ST_P2_CHECK: begin
            if ((i_ff >= n_eff) || (j_ff >= n_eff)) begin
               c_wr_en   = 1'b1;
               c_wr_data = '0;
               state_in  = tmps_pkg::ST_P2_CHECK;
               if (j_ff == order_last) begin
                  j_in = '0;
                  if (i_ff == order_last) begin
                     i_in     = '0;
                     state_in = tmps_pkg::ST_IDLE;
                  end else begin
                     i_in = i_ff + 1'b1;
                  end
               end else begin
                  j_in = j_ff + 1'b1;
               end
            end else begin
               k_in     = j_ff;
               acc_in   = '0;
               mark_in  = 1'b0;
               state_in = tmps_pkg::ST_P2_RD;
            end
         end
         tmps_pkg::ST_P2_RD: begin
            d_rd_en   = 1'b1;
            a_rd_en   = 1'b1;
            a_rd_addr = cell_addr(j_ff, k_ff);
            state_in  = tmps_pkg::ST_P2_MUL_LO;
         end
         tmps_pkg::ST_P2_MUL_LO: begin
            mark_in  = mark_ff || d_rd_data[VW];
            state_in = tmps_pkg::ST_P2_ACC_LO;
         end
         tmps_pkg::ST_P2_ACC_LO: begin
            acc_in   = acc_lo_sum;
            state_in = tmps_pkg::ST_P2_MUL_HI;
         end
         tmps_pkg::ST_P2_MUL_HI: begin
            state_in = tmps_pkg::ST_P2_ACC_HI;
         end
         tmps_pkg::ST_P2_ACC_HI: begin
            acc_in = acc_hi_sum;
            if (k_ff == n_last) begin
               state_in = tmps_pkg::ST_P2_SHIFT;
            end else begin
               k_in     = k_ff + 1'b1;
               state_in = tmps_pkg::ST_P2_RD;
            end
         end
         // Q48.48 down to Q32.32, rounding toward minus infinity.
         tmps_pkg::ST_P2_SHIFT: begin
            acc_in   = acc_ff >>> 16;
            k_in     = '0;
            state_in = tmps_pkg::ST_P3_RD;
         end
         tmps_pkg::ST_P3_RD: begin
            b0_rd_en   = 1'b1;
            b1_rd_en   = 1'b1;
            b0_rd_addr = cell_addr(k_ff, i_ff);
            state_in   = tmps_pkg::ST_P3_MUL;
         end
         tmps_pkg::ST_P3_MUL: begin
            state_in = tmps_pkg::ST_P3_ACC;
         end
         tmps_pkg::ST_P3_ACC: begin
            acc_in = acc_lo_sum;
            if (k_ff == n_last) begin
               state_in = tmps_pkg::ST_P2_WR;
            end else begin
               k_in     = k_ff + 1'b1;
               state_in = tmps_pkg::ST_P3_RD;
            end
         end
         tmps_pkg::ST_P2_WR: begin
            c_wr_en  = 1'b1;
            state_in = tmps_pkg::ST_P2_CHECK;
            if (j_ff == order_last) begin
               j_in = '0;
               if (i_ff == order_last) begin
                  i_in     = '0;
                  state_in = tmps_pkg::ST_IDLE;
               end else begin
                  i_in = i_ff + 1'b1;
               end
            end else begin
               j_in = j_ff + 1'b1;
            end
         end
         default: begin
            state_in = tmps_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= tmps_pkg::ST_IDLE;
         i_ff     <= '0;
         j_ff     <= '0;
         k_ff     <= '0;
         mark_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         i_ff     <= i_in;
         j_ff     <= j_in;
         k_ff     <= k_in;
         mark_ff  <= mark_in;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff  <= acc_in;
      prod_ff <= op_a * op_b;
   end

   a_pop_only_idle: assert property (@(posedge clock) disable iff (reset)
      cmd_pop |-> (state_ff == tmps_pkg::ST_IDLE) && cmd_valid)
      else $error("command taken while engine busy");

   a_resp_after_read: assert property (@(posedge clock) disable iff (reset)
      (state_ff == tmps_pkg::ST_READ_RESP) |-> $past(c_rd_en))
      else $error("response without a result read");

   a_c_write_states: assert property (@(posedge clock) disable iff (reset)
      c_wr_en |-> (state_ff == tmps_pkg::ST_P2_CHECK) || (state_ff == tmps_pkg::ST_P2_WR))
      else $error("result store written outside compute");

   a_hi_after_lo: assert property (@(posedge clock) disable iff (reset)
      (state_ff == tmps_pkg::ST_P2_MUL_HI) |-> $past(state_ff, 2) == tmps_pkg::ST_P2_MUL_LO)
      else $error("upper half multiplied out of order");

endmodule

[rtl/core/triangular_matrix_product_sum_top.sv]
// Triangular matrix product sum engine.
// Requests enter through a queue-style port: a request is taken on a rising edge with
// push high and full low. func selects load A, load B, compute or read C. Loads write
// one Q16.16 element; a compute forms C = A*B*At + Bt*Bt over the configured order n,
// with A treated as upper triangular; a read returns one Q32.32 entry of C and its
// saturation mark on the response queue (valid while empty is low, taken with pop).
// The user must write the order n through the csr channel (valid/ready) while the
// block is idle; the block itself does not enforce this. A load is written when the
// engine takes it from the request queue; a read answer enters the response queue
// from ST_READ_RESP. The single shared 33x33 multiplier takes each term through read,
// multiply and accumulate states, a 64-bit intermediate term in two halves, one term
// at a time. Requests behind a compute wait in the queue.
// Reset clears the queues and sets n to 16; the matrix stores keep no reset value.
// When the receiver stalls, up to two answers wait in the response queue; a further
// read stays in the request queue, which then fills and raises full.
module triangular_matrix_product_sum_top #(
   parameter int MAX_ORDER = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 push,
   output logic                                 full,
   input  logic [tmps_pkg::FUNC_W-1:0]          req_func,
   input  logic [tmps_pkg::INDEX_W-1:0]         req_row_index,
   input  logic [tmps_pkg::INDEX_W-1:0]         req_col_index,
   input  logic signed [tmps_pkg::ELEM_W-1:0]   req_elem_value,
   output logic                                 empty,
   input  logic                                 pop,
   output logic signed [tmps_pkg::VALUE_W-1:0]  rsp_result_value,
   output logic                                 rsp_saturated,
   input  logic                                 valid,
   output logic                                 ready,
   input  logic [tmps_pkg::SIZE_W-1:0]          csr_size_in_use
);

   localparam int IDX_W  = (MAX_ORDER > 1) ? $clog2(MAX_ORDER) : 1;
   localparam int ADDR_W = 2 * IDX_W;
   localparam int CNT_W  = $clog2(MAX_ORDER + 1);
   localparam int OPTR_W = $clog2(tmps_pkg::OUT_DEPTH);
   localparam int OCNT_W = $clog2(tmps_pkg::OUT_DEPTH + 1);

   logic [tmps_pkg::SIZE_W-1:0]  size_ff;
   logic [7:0]                   n_wide;
   logic [CNT_W-1:0]             n_eff;

   logic                         cmd_valid;
   logic                         cmd_pop;
   tmps_pkg::cmd_kind_type       cmd_kind;
   logic [ADDR_W-1:0]            cmd_addr;
   logic [tmps_pkg::ELEM_W-1:0]  cmd_value;

   logic                         rsp_push;
   logic [tmps_pkg::VALUE_W-1:0] rsp_value;
   logic                         rsp_sat;
   logic                         rsp_room;

   logic [tmps_pkg::VALUE_W-1:0] out_value_ff [tmps_pkg::OUT_DEPTH];
   logic                         out_sat_ff   [tmps_pkg::OUT_DEPTH];
   logic [OPTR_W-1:0]            out_wr_ptr_ff;
   logic [OPTR_W-1:0]            out_rd_ptr_ff;
   logic [OCNT_W-1:0]            out_count_ff;
   logic                         out_pop;

   // The order register is always writable; a zero acts as one and large values clamp.
   assign ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff <= tmps_pkg::SIZE_RESET;
      end else if (valid && ready) begin
         size_ff <= csr_size_in_use;
      end
   end

   always_comb begin
      if (size_ff == '0) begin
         n_wide = 8'd1;
      end else if ({3'd0, size_ff} > 8'(MAX_ORDER)) begin
         n_wide = 8'(MAX_ORDER);
      end else begin
         n_wide = {3'd0, size_ff};
      end
      n_eff = n_wide[CNT_W-1:0];
   end

   tmps_front #(.MAX_ORDER(MAX_ORDER)) u_front (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .full       (full),
      .func       (req_func),
      .row_index  (req_row_index),
      .col_index  (req_col_index),
      .elem_value (req_elem_value),
      .cmd_valid  (cmd_valid),
      .cmd_pop    (cmd_pop),
      .cmd_kind   (cmd_kind),
      .cmd_addr   (cmd_addr),
      .cmd_value  (cmd_value)
   );

   tmps_back #(.MAX_ORDER(MAX_ORDER)) u_back (
      .clock     (clock),
      .reset     (reset),
      .n_eff     (n_eff),
      .cmd_valid (cmd_valid),
      .cmd_pop   (cmd_pop),
      .cmd_kind  (cmd_kind),
      .cmd_addr  (cmd_addr),
      .cmd_value (cmd_value),
      .rsp_room  (rsp_room),
      .rsp_push  (rsp_push),
      .rsp_value (rsp_value),
      .rsp_sat   (rsp_sat)
   );

   // Response queue. The engine has at most one read in flight, so a free slot at
   // dispatch is still free when the answer arrives.
   assign rsp_room         = (out_count_ff != OCNT_W'(tmps_pkg::OUT_DEPTH));
   assign empty            = (out_count_ff == '0);
   assign out_pop          = pop && !empty;
   assign rsp_result_value = $signed(out_value_ff[out_rd_ptr_ff]);
   assign rsp_saturated    = out_sat_ff[out_rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         out_wr_ptr_ff <= '0;
         out_rd_ptr_ff <= '0;
         out_count_ff  <= '0;
      end else begin
         if (rsp_push) begin
            out_wr_ptr_ff <= out_wr_ptr_ff + 1'b1;
         end
         if (out_pop) begin
            out_rd_ptr_ff <= out_rd_ptr_ff + 1'b1;
         end
         out_count_ff <= out_count_ff + OCNT_W'(rsp_push) - OCNT_W'(out_pop);
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_push) begin
         out_value_ff[out_wr_ptr_ff] <= rsp_value;
         out_sat_ff[out_wr_ptr_ff]   <= rsp_sat;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      rsp_push |-> out_count_ff != OCNT_W'(tmps_pkg::OUT_DEPTH))
      else $error("response queue overflow");

endmodule

[sim/tmps_scoreboard.sv]
`timescale 1ns / 1ps

// Predicts the C entries returned by reads and checks each response in order.
class tmps_scoreboard;
   logic [31:0] a_mem [256];
   logic [31:0] b_mem [256];
   logic [63:0] d_mem [256];
   bit          d_clamp [256];
   logic [63:0] c_mem [256];
   bit          c_clamp [256];
   logic [tmps_pkg::SIZE_W-1:0] order_reg;

   logic [63:0] c_value_q [$];
   bit          c_clamp_q [$];

   int errors;
   int reads_checked;
   int clamped_seen;
   int computes;

   function new();
      order_reg     = tmps_pkg::SIZE_RESET;
      errors        = 0;
      reads_checked = 0;
      clamped_seen  = 0;
      computes      = 0;
   endfunction

   function void write_order(logic [tmps_pkg::SIZE_W-1:0] v);
      order_reg = v;
   endfunction

   function int pending();
      return c_value_q.size();
   endfunction

   function logic signed [127:0] sx32(logic [31:0] v);
      return {{96{v[31]}}, v};
   endfunction

   function logic signed [127:0] sx64(logic [63:0] v);
      return {{64{v[63]}}, v};
   endfunction

   function logic [63:0] clamp64(logic signed [127:0] acc, output bit hit);
      if (sx64(acc[63:0]) == acc) begin
         hit = 0;
         return acc[63:0];
      end
      hit = 1;
      return acc[127] ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
   endfunction

   // Forms D = A*B with A upper triangular, then C = D*At + Bt*Bt.
   function void run_compute();
      int n;
      logic signed [127:0] acc;
      bit hit;
      bit mark;
      n = order_reg;
      if (n == 0) n = 1;
      if (n > 16) n = 16;
      computes++;
      for (int i = 0; i < n; i++) begin
         for (int j = 0; j < n; j++) begin
            acc = 0;
            for (int k = i; k < n; k++)
               acc = acc + sx32(a_mem[i*16+k]) * sx32(b_mem[k*16+j]);
            d_mem[i*16+j] = clamp64(acc, hit);
            d_clamp[i*16+j] = hit;
         end
      end
      for (int i = 0; i < 16; i++) begin
         for (int j = 0; j < 16; j++) begin
            if (i >= n || j >= n) begin
               c_mem[i*16+j] = 0;
               c_clamp[i*16+j] = 0;
            end else begin
               acc = 0;
               mark = 0;
               for (int k = j; k < n; k++) begin
                  acc = acc + sx64(d_mem[i*16+k]) * sx32(a_mem[j*16+k]);
                  if (d_clamp[i*16+k]) mark = 1;
               end
               acc = acc >>> 16;
               for (int k = 0; k < n; k++)
                  acc = acc + sx32(b_mem[k*16+i]) * sx32(b_mem[j*16+k]);
               c_mem[i*16+j] = clamp64(acc, hit);
               c_clamp[i*16+j] = hit | mark;
            end
         end
      end
   endfunction

   function void note_request(logic [1:0] f, logic [3:0] r, logic [3:0] c, logic [31:0] v);
      logic [7:0] idx;
      idx = {r, c};
      case (f)
         tmps_pkg::FUNC_LOAD_A:  a_mem[idx] = v;
         tmps_pkg::FUNC_LOAD_B:  b_mem[idx] = v;
         tmps_pkg::FUNC_COMPUTE: run_compute();
         default: begin
            c_value_q.push_back(c_mem[idx]);
            c_clamp_q.push_back(c_clamp[idx]);
         end
      endcase
   endfunction

   function void check_response(logic [63:0] v, logic s);
      logic [63:0] want_v;
      bit want_s;
      if (c_value_q.size() == 0) begin
         $error("response with no read outstanding: result_value %h", v);
         errors++;
         return;
      end
      want_v = c_value_q.pop_front();
      want_s = c_clamp_q.pop_front();
      reads_checked++;
      if (want_s) clamped_seen++;
      if (v !== want_v) begin
         $error("result_value: expected %h, actual %h", want_v, v);
         errors++;
      end
      if (s !== want_s) begin
         $error("saturated: expected %0b, actual %0b", want_s, s);
         errors++;
      end
   endfunction
endclass

[sim/tb_triangular_matrix_product_sum_top.sv]
`timescale 1ns / 1ps

module tb_triangular_matrix_product_sum_top;

   logic                                clock = 0;
   logic                                reset = 1;
   logic                                push = 0;
   logic                                full;
   logic [tmps_pkg::FUNC_W-1:0]         req_func = tmps_pkg::FUNC_LOAD_A;
   logic [tmps_pkg::INDEX_W-1:0]        req_row_index = '0;
   logic [tmps_pkg::INDEX_W-1:0]        req_col_index = '0;
   logic signed [tmps_pkg::ELEM_W-1:0]  req_elem_value = '0;
   logic                                empty;
   logic                                pop = 0;
   logic signed [tmps_pkg::VALUE_W-1:0] rsp_result_value;
   logic                                rsp_saturated;
   logic                                valid = 0;
   logic                                ready;
   logic [tmps_pkg::SIZE_W-1:0]         csr_size_in_use = '0;

   triangular_matrix_product_sum_top DUT (
      .clock(clock), .reset(reset),
      .push(push), .full(full),
      .req_func(req_func), .req_row_index(req_row_index),
      .req_col_index(req_col_index), .req_elem_value(req_elem_value),
      .empty(empty), .pop(pop),
      .rsp_result_value(rsp_result_value), .rsp_saturated(rsp_saturated),
      .valid(valid), .ready(ready), .csr_size_in_use(csr_size_in_use)
   );

   // Clock with a 10 ns period.
   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   tmps_scoreboard sb = new();

   // Which matrix cells have been loaded, so that a compute never reads unwritten data.
   bit a_loaded [256];
   bit b_loaded [256];

   // When set, the matching side draws no random gaps between its requests or pops.
   bit quiet_tx = 0;
   bit quiet_rx = 0;
   // Asks the response side to hold pop low for a long stretch.
   bit hold_pop_req = 0;
   int requests_sent = 0;
   int csr_writes = 0;

   function int draw_gap(bit quiet);
      if (quiet) return 0;
      return $urandom_range(0, 19);
   endfunction

   function logic [31:0] rand_elem();
      case ($urandom_range(0, 5))
         0:       return 32'h8000_0000;
         1:       return 32'h7FFF_FFFF;
         2, 3:    return $urandom;
         default: return $urandom_range(0, 1 << 19) - (1 << 18);
      endcase
   endfunction

   // Sends one request after a random gap. push stays high between back-to-back
   // requests, so it never gets two assignments in the same time step.
   task automatic send_request(logic [1:0] f, logic [3:0] r, logic [3:0] c, logic [31:0] v);
      int gap;
      if ($urandom_range(0, 39) == 0) quiet_tx = !quiet_tx;
      gap = draw_gap(quiet_tx);
      if (gap > 0) begin
         push <= 0;
         repeat (gap) @(posedge clock);
      end
      push           <= 1;
      req_func       <= f;
      req_row_index  <= r;
      req_col_index  <= c;
      req_elem_value <= v;
      do @(posedge clock); while (full);
      sb.note_request(f, r, c, v);
      requests_sent++;
      if (f == tmps_pkg::FUNC_LOAD_A) a_loaded[{r, c}] = 1;
      if (f == tmps_pkg::FUNC_LOAD_B) b_loaded[{r, c}] = 1;
   endtask

   function int active_order();
      int n;
      n = sb.order_reg;
      if (n == 0) n = 1;
      if (n > 16) n = 16;
      return n;
   endfunction

   // Loads every cell the next compute will read that has not been written yet,
   // then computes and follows with one read. The read makes the end of the
   // compute visible as a response, so an idle engine is seen by an empty queue.
   task automatic compute_and_read();
      int n;
      n = active_order();
      for (int i = 0; i < n; i++)
         for (int j = 0; j < n; j++) begin
            if (j >= i && !a_loaded[i*16+j])
               send_request(tmps_pkg::FUNC_LOAD_A, 4'(i), 4'(j), rand_elem());
            if (!b_loaded[i*16+j])
               send_request(tmps_pkg::FUNC_LOAD_B, 4'(i), 4'(j), rand_elem());
         end
      send_request(tmps_pkg::FUNC_COMPUTE, 4'($urandom), 4'($urandom), $urandom);
      send_request(tmps_pkg::FUNC_READ, 4'($urandom_range(0, n - 1)),
                   4'($urandom_range(0, n - 1)), $urandom);
   endtask

   // Waits until the block is idle, then writes the order register.
   task automatic write_order(logic [tmps_pkg::SIZE_W-1:0] v);
      push <= 0;
      while (sb.pending() > 0) @(posedge clock);
      // Loads may still be draining out of the request queue.
      repeat (20) @(posedge clock);
      valid           <= 1;
      csr_size_in_use <= v;
      do @(posedge clock); while (!ready);
      sb.write_order(v);
      csr_writes++;
      valid <= 0;
   endtask

   // One phase of random traffic at the given order. Large orders make a compute
   // slow, so those phases compute only once.
   task automatic run_phase(logic [tmps_pkg::SIZE_W-1:0] order, int count);
      int n;
      int pick;
      write_order(order);
      n = active_order();
      compute_and_read();
      for (int t = 0; t < count; t++) begin
         pick = $urandom_range(0, 99);
         if (pick < 33)
            send_request(tmps_pkg::FUNC_LOAD_A, 4'($urandom), 4'($urandom), rand_elem());
         else if (pick < 66)
            send_request(tmps_pkg::FUNC_LOAD_B, 4'($urandom), 4'($urandom), rand_elem());
         else if (pick < 72 && n <= 6)
            compute_and_read();
         else if ($urandom_range(0, 1) == 0)
            // Reads mostly inside the order, where C carries real data.
            send_request(tmps_pkg::FUNC_READ, 4'($urandom_range(0, n - 1)),
                         4'($urandom_range(0, n - 1)), $urandom);
         else
            send_request(tmps_pkg::FUNC_READ, 4'($urandom), 4'($urandom), $urandom);
      end
   endtask

   // Response side: pops with random gaps, and on request holds off for a long
   // stretch so that the block fills up and raises full.
   initial begin : response_side
      int gap;
      @(negedge reset);
      forever begin
         if (hold_pop_req) begin
            pop <= 0;
            repeat (400) @(posedge clock);
            hold_pop_req = 0;
         end
         if ($urandom_range(0, 39) == 0) quiet_rx = !quiet_rx;
         gap = draw_gap(quiet_rx);
         if (gap > 0) begin
            pop <= 0;
            repeat (gap) @(posedge clock);
         end
         pop <= 1;
         do @(posedge clock); while (empty);
         sb.check_response(rsp_result_value, rsp_saturated);
      end
   end

   initial begin : stimulus
      logic [tmps_pkg::SIZE_W-1:0] orders [9];
      orders = '{5'd0, 5'd3, 5'd31, 5'd1, 5'd5, 5'd2, 5'd16, 5'd4, 5'd6};
      repeat (10) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // Directed part at order 2: a clamped product row, extremes of every field,
      // a read outside the order and a load into the last cell.
      write_order(5'd2);
      send_request(tmps_pkg::FUNC_LOAD_A, 4'd0, 4'd0, 32'h8000_0000);
      send_request(tmps_pkg::FUNC_LOAD_A, 4'd0, 4'd1, 32'h8000_0000);
      send_request(tmps_pkg::FUNC_LOAD_A, 4'd1, 4'd1, 32'h7FFF_FFFF);
      send_request(tmps_pkg::FUNC_LOAD_A, 4'd1, 4'd0, 32'h7FFF_FFFF);
      send_request(tmps_pkg::FUNC_LOAD_B, 4'd0, 4'd0, 32'h8000_0000);
      send_request(tmps_pkg::FUNC_LOAD_B, 4'd0, 4'd1, 32'h8000_0000);
      send_request(tmps_pkg::FUNC_LOAD_B, 4'd1, 4'd0, 32'h8000_0000);
      send_request(tmps_pkg::FUNC_LOAD_B, 4'd1, 4'd1, 32'h0000_0000);
      send_request(tmps_pkg::FUNC_COMPUTE, 4'd15, 4'd15, 32'hFFFF_FFFF);
      send_request(tmps_pkg::FUNC_READ, 4'd0, 4'd0, 32'd0);
      send_request(tmps_pkg::FUNC_READ, 4'd0, 4'd1, 32'd0);
      send_request(tmps_pkg::FUNC_READ, 4'd1, 4'd0, 32'd0);
      send_request(tmps_pkg::FUNC_READ, 4'd1, 4'd1, 32'd0);
      send_request(tmps_pkg::FUNC_READ, 4'd15, 4'd15, 32'd0);
      send_request(tmps_pkg::FUNC_READ, 4'd15, 4'd0, 32'd0);
      send_request(tmps_pkg::FUNC_LOAD_A, 4'd15, 4'd15, 32'h7FFF_FFFF);
      send_request(tmps_pkg::FUNC_LOAD_B, 4'd15, 4'd15, 32'h8000_0000);
      send_request(tmps_pkg::FUNC_READ, 4'd0, 4'd15, 32'd0);

      for (int p = 0; p < 9; p++) begin
         run_phase(orders[p], 150);
         if (p == 1) begin
            // Back pressure: the response side stalls while reads keep coming.
            hold_pop_req = 1;
            quiet_tx = 1;
            for (int t = 0; t < 40; t++)
               send_request(tmps_pkg::FUNC_READ, 4'($urandom), 4'($urandom), 32'd0);
            quiet_tx = 0;
         end
      end
      push <= 0;

      while (sb.pending() > 0) @(posedge clock);
      repeat (50) @(posedge clock);
      $display("Sent %0d requests over %0d order settings with %0d computes.",
               requests_sent, csr_writes, sb.computes);
      $display("Checked %0d reads, %0d of them with the saturation mark set.",
               sb.reads_checked, sb.clamped_seen);
      if (sb.errors == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

   // Hard limit on the run time.
   initial begin : watchdog
      #20ms;
      $display("FAIL");
      $finish;
   end

endmodule
